// ----- design/insertion_sorter_defines.svh -----
// Assertion macros for the insertion sorter checker.
// Needs a clock named clk and an active-low reset named arst_n where used.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ISORT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ISORT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/isort_pkg.sv -----
// Shared types and constants of the insertion sorter.
// No dependencies; used by every module of the block.
package isort_pkg;

	localparam int DEF_SORT_DEPTH = 16;
	localparam int DATA_W = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_res;
		logic                     last_res;
		logic                     dropped;
	} result_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic one_left;
	} status_t;

endpackage

// ----- design/insertion_sorter.sv -----
// Streaming insertion sorter for signed 32-bit values. Each accepted item is
// inserted into a sorted register store by a parallel compare-and-shift
// across all entries, so a run is taken at one item per cycle. The item
// marked last starts the emission: the store shifts out one value per
// cycle unless stalled, from its lowest entry, in ascending order, so a run
// of n stored values takes n result transfers, during which item is stalled.
// Values beyond SORT_DEPTH in a run are dropped and every result of that run
// carries the dropped flag. Depends on isort_pkg, isort_ctrl and isort_dp.
module insertion_sorter #(
	parameter int SORT_DEPTH = isort_pkg::DEF_SORT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  isort_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output isort_pkg::result_t result
);

	isort_pkg::cmd_t    cmd;
	isort_pkg::status_t status;

	isort_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_last    (item.last),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	isort_dp #(
		.SORT_DEPTH (SORT_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.status (status),
		.result (result)
	);

endmodule

// ----- design/isort_ctrl.sv -----
// Controller of the insertion sorter: takes items, then runs the emission.
// Depends on isort_pkg for the command and status structs.
module isort_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_last,
	output logic               item_stall,
	output logic               result_valid,
	input  logic               result_stall,
	input  isort_pkg::status_t status,
	output isort_pkg::cmd_t    cmd
);

	typedef enum logic {
		ST_FILL,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign item_stall   = (state_q == ST_EMIT);
	assign result_valid = (state_q == ST_EMIT);
	assign cmd.ins      = (state_q == ST_FILL) && item_valid;
	assign cmd.pop      = (state_q == ST_EMIT) && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (item_valid && item_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!result_stall && status.one_left) begin
						state_q <= ST_FILL;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

endmodule

// ----- design/isort_dp.sv -----
// Datapath of the insertion sorter: register store with parallel
// compare-and-shift insertion and shift-down emission. Depends on isort_pkg.
module isort_dp #(
	parameter int SORT_DEPTH = isort_pkg::DEF_SORT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  isort_pkg::cmd_t    cmd,
	input  isort_pkg::item_t   item,
	output isort_pkg::status_t status,
	output isort_pkg::result_t result
);

	localparam int CW = $clog2(SORT_DEPTH + 1);

	logic signed [isort_pkg::DATA_W-1:0] store_q [SORT_DEPTH];
	logic [CW-1:0]                       count_q;
	logic                                ovf_q;
	logic [SORT_DEPTH-1:0]               gt;
	logic                                do_ins;

	assign status.full     = (count_q == CW'(SORT_DEPTH));
	assign status.one_left = (count_q == CW'(1));
	assign do_ins          = cmd.ins && !status.full;

	assign result.value_res = store_q[0];
	assign result.last_res  = status.one_left;
	assign result.dropped   = ovf_q;

	for (genvar g = 0; g < SORT_DEPTH; g++) begin : g_cell
		assign gt[g] = (CW'(g) < count_q) && ($signed(store_q[g]) > $signed(item.value));

		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (do_ins) begin
					if (gt[g] || (count_q == CW'(g))) begin
						store_q[g] <= item.value;
					end
				end else if (cmd.pop) begin
					store_q[g] <= store_q[g+1];
				end
			end
		end else if (g == SORT_DEPTH - 1) begin : g_top
			always_ff @(posedge clk) begin
				if (do_ins) begin
					if (gt[g-1]) begin
						store_q[g] <= store_q[g-1];
					end else if (gt[g] || (count_q == CW'(g))) begin
						store_q[g] <= item.value;
					end
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (do_ins) begin
					if (gt[g-1]) begin
						store_q[g] <= store_q[g-1];
					end else if (gt[g] || (count_q == CW'(g))) begin
						store_q[g] <= item.value;
					end
				end else if (cmd.pop) begin
					store_q[g] <= store_q[g+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.ins) begin
			if (status.full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end else if (cmd.pop) begin
			count_q <= count_q - CW'(1);
			if (status.one_left) begin
				ovf_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/isort_checker.sv -----
// Port-level checks of the insertion sorter, bound to the top level.
// Depends on isort_pkg and insertion_sorter_defines.svh.
`include "insertion_sorter_defines.svh"

module isort_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input isort_pkg::item_t   item,
	input logic               result_valid,
	input logic               result_stall,
	input isort_pkg::result_t result
);

	`ISORT_ASSERT(a_stall_during_emit, item_stall == result_valid, "item stall differs from result valid")
	`ISORT_ASSERT(a_last_starts_emit, (item_valid && !item_stall && item.last) |=> result_valid, "no result after last item")
	`ISORT_ASSERT(a_plain_item_quiet, (item_valid && !item_stall && !item.last) |=> !result_valid, "result without last item")
	`ISORT_ASSERT(a_emit_continues, (result_valid && !result_stall && !result.last_res) |=> result_valid, "emission ended early")
	`ISORT_ASSERT(a_emit_ends, (result_valid && !result_stall && result.last_res) |=> !result_valid, "emission ran past last result")

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);
